>>> src/bahd_pkg.sv
package bahd_pkg;

   localparam logic [2:0] PREFIX_LEN = 3'd6;
   localparam logic [9:0] LEN_MAX = 10'd1023;
   localparam logic [7:0] MAX_FIELD_RESET = 8'd64;
   localparam logic [9:0] DECODE_LIMIT_RESET = 10'd511;
   localparam int FIFO_DEPTH_DEFAULT = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_FIELD = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECODE_LIMIT = 4'd1;
   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_PREFIX = 3'd1,
      ST_OVERFLOW   = 3'd2,
      ST_NO_COLON   = 3'd3,
      ST_TOO_LONG   = 3'd4
   } status_type;

   // one classified character, front to back
   typedef struct packed {
      logic       active;
      logic       is_pad;
      logic       is_sextet;
      logic [5:0] sextet;
      logic       last;
      logic       prefix_bad;
   } token_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       field_select;
      logic       is_status;
      logic [2:0] status_code;
      logic       end_of_run;
   } result_type;

   typedef struct packed {
      logic [7:0] max_field;
      logic [9:0] decode_limit;
   } cfg_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h42;
         3'd1: ch = 8'h61;
         3'd2: ch = 8'h73;
         3'd3: ch = 8'h69;
         3'd4: ch = 8'h63;
         3'd5: ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // bit 6 set: character is in the base64 alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

>>> src/bahd_if.sv
interface bahd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_char;
   logic       last_char;
   modport source (output valid, output header_char, output last_char, input ready);
   modport sink (input valid, input header_char, input last_char, output ready);
endinterface

interface bahd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       field_select;
   logic       is_status;
   logic [2:0] status_code;
   logic       end_of_run;
   modport source (output valid, output out_byte, output field_select, output is_status,
                   output status_code, output end_of_run, input ready);
   modport sink (input valid, input out_byte, input field_select, input is_status,
                 input status_code, input end_of_run, output ready);
endinterface

interface bahd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bahd_pkg::CSR_ADDR_W-1:0] addr;
   logic [bahd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

>>> src/basic_auth_header_decoder.sv
// a char taken on req is written into the queue; the back end pops it and registers its result in
// the output register that drives rsp
// throughput: one char per cycle unless rsp stalls, set by the back end's one decode step per entry
// a last char that also yields a byte gives two results; the status is loaded in the cycle
// the byte is taken, and the queue is not popped meanwhile
// reset: synchronous, active high; clears the run state, the queue and the output stage,
// and restores max_field_length to 64 and decode_limit to 511
module basic_auth_header_decoder #(
   parameter int FIFO_DEPTH = bahd_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bahd_req_if.sink    req_chan,
   bahd_rsp_if.source  rsp_chan,
   bahd_csr_if.sink    csr_chan
);
   import bahd_pkg::*;

   // configuration registers
   logic [7:0] max_field_ff;
   logic [9:0] decode_limit_ff;
   cfg_type    cfg;

   // front to queue
   logic       push;
   token_type  push_token;
   logic       fifo_full;

   // queue to back
   logic       tok_valid;
   token_type  tok;
   logic       pop;

   // csr writes always taken; user changes config only while idle, block does not enforce it
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_field_ff <= MAX_FIELD_RESET;
         decode_limit_ff <= DECODE_LIMIT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            CSR_MAX_FIELD: max_field_ff <= csr_chan.data[7:0];
            CSR_DECODE_LIMIT: decode_limit_ff <= csr_chan.data[9:0];
            // writes past the register list are dropped
            default: max_field_ff <= max_field_ff;
         endcase
      end
   end

   assign cfg.max_field = max_field_ff;
   assign cfg.decode_limit = decode_limit_ff;

   // front: prefix check and char classification, one transaction per cycle while the queue has room
   bahd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_token (push_token)
   );

   // short queue so a stalled rsp side does not stall req right away
   bahd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_token),
      .full      (fifo_full),
      .pop       (pop),
      .rd_valid  (tok_valid),
      .rd_data   (tok)
   );

   // back: base64 bit accumulation, byte routing, lengths and final status
   bahd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .tok_valid (tok_valid),
      .tok       (tok),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> src/bahd_front.sv
module bahd_front (
   input  logic                clock,
   input  logic                reset,
   bahd_req_if.sink            req_chan,
   input  logic                fifo_full,
   output logic                push,
   output bahd_pkg::token_type push_token
);
   import bahd_pkg::*;

   logic [2:0] prefix_idx_ff, prefix_idx_in;
   logic       prefix_fail_ff, prefix_fail_in;
   logic [6:0] sx;

   assign req_chan.ready = !fifo_full;
   assign push = req_chan.valid && !fifo_full;

   always_comb begin
      sx = sextet_of(req_chan.header_char);
      prefix_idx_in = prefix_idx_ff;
      prefix_fail_in = prefix_fail_ff;
      if (prefix_idx_ff < PREFIX_LEN) begin
         if (req_chan.header_char != prefix_char(prefix_idx_ff)) begin
            prefix_fail_in = 1'b1;
         end
         prefix_idx_in = prefix_idx_ff + 3'd1;
      end
      push_token.active = (prefix_idx_ff == PREFIX_LEN) && !prefix_fail_ff;
      push_token.is_pad = (req_chan.header_char == CHAR_PAD);
      push_token.is_sextet = sx[6];
      push_token.sextet = sx[5:0];
      push_token.last = req_chan.last_char;
      push_token.prefix_bad = prefix_fail_in || (prefix_idx_in < PREFIX_LEN);
      if (req_chan.last_char) begin
         prefix_idx_in = 3'd0;
         prefix_fail_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_idx_ff <= 3'd0;
         prefix_fail_ff <= 1'b0;
      end else if (push) begin
         prefix_idx_ff <= prefix_idx_in;
         prefix_fail_ff <= prefix_fail_in;
      end
   end

endmodule

>>> src/bahd_fifo.sv
module bahd_fifo #(
   parameter int DEPTH = bahd_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bahd_pkg::token_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                rd_valid,
   output bahd_pkg::token_type rd_data
);
   import bahd_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && rd_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10: count_ff <= count_ff + 1'b1;
            2'b01: count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> src/bahd_back.sv
module bahd_back (
   input  logic                clock,
   input  logic                reset,
   input  bahd_pkg::cfg_type   cfg,
   input  logic                tok_valid,
   input  bahd_pkg::token_type tok,
   output logic                pop,
   bahd_rsp_if.source          rsp_chan
);
   import bahd_pkg::*;

   logic        pad_ff, pad_upd, pad_in;
   logic [11:0] acc_ff, acc_upd, acc_in;
   logic [2:0]  pend_ff, pend_upd, pend_in;
   logic [9:0]  count_ff, count_upd, count_in;
   logic        ovf_ff, ovf_upd, ovf_in;
   logic        colon_ff, colon_upd, colon_in;
   logic        term_ff, term_upd, term_in;
   logic [9:0]  user_ff, user_upd, user_in;
   logic [9:0]  pass_ff, pass_upd, pass_in;

   logic        out_valid_ff;
   result_type  out_data_ff;
   logic        stat_pend_ff;
   result_type  stat_data_ff;

   logic [11:0] acc_new;
   logic [3:0]  pb_sum;
   logic [7:0]  dec_byte;
   logic        emit;
   status_type  code;
   result_type  byte_res, stat_res;
   logic        out_free;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign pop = tok_valid && !stat_pend_ff && out_free;

   always_comb begin
      acc_new = {acc_ff[5:0], tok.sextet};
      pb_sum = {1'b0, pend_ff} + 4'd6;
      dec_byte = 8'(acc_new >> pb_sum[2:0]);
      pad_upd = pad_ff;
      acc_upd = acc_ff;
      pend_upd = pend_ff;
      count_upd = count_ff;
      ovf_upd = ovf_ff;
      colon_upd = colon_ff;
      term_upd = term_ff;
      user_upd = user_ff;
      pass_upd = pass_ff;
      emit = 1'b0;
      if (tok.active && !pad_ff && !ovf_ff) begin
         if (tok.is_pad) begin
            pad_upd = 1'b1;
         end else if (tok.is_sextet) begin
            acc_upd = acc_new;
            // subtracting eight just clears bit 3
            pend_upd = pb_sum[2:0];
            if (pb_sum[3]) begin
               if (count_ff >= cfg.decode_limit) begin
                  ovf_upd = 1'b1;
               end else begin
                  count_upd = count_ff + 10'd1;
                  if (term_ff) begin
                     emit = 1'b0;
                  end else if (dec_byte == 8'd0) begin
                     term_upd = 1'b1;
                  end else if (!colon_ff && dec_byte == CHAR_COLON) begin
                     colon_upd = 1'b1;
                  end else begin
                     emit = 1'b1;
                     if (colon_ff) begin
                        if (pass_ff < LEN_MAX) pass_upd = pass_ff + 10'd1;
                     end else begin
                        if (user_ff < LEN_MAX) user_upd = user_ff + 10'd1;
                     end
                  end
               end
            end
         end
      end

      if (tok.prefix_bad) begin
         code = ST_BAD_PREFIX;
      end else if (ovf_upd) begin
         code = ST_OVERFLOW;
      end else if (!colon_upd) begin
         code = ST_NO_COLON;
      end else if (user_upd >= {2'b00, cfg.max_field} || pass_upd >= {2'b00, cfg.max_field}) begin
         code = ST_TOO_LONG;
      end else begin
         code = ST_OK;
      end

      byte_res = '{out_byte: dec_byte, field_select: colon_ff, is_status: 1'b0,
                   status_code: ST_OK, end_of_run: 1'b0};
      stat_res = '{out_byte: 8'd0, field_select: 1'b0, is_status: 1'b1,
                   status_code: code, end_of_run: 1'b1};

      pad_in = pad_ff;
      acc_in = acc_ff;
      pend_in = pend_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      colon_in = colon_ff;
      term_in = term_ff;
      user_in = user_ff;
      pass_in = pass_ff;
      if (pop) begin
         if (tok.last) begin
            pad_in = 1'b0;
            acc_in = '0;
            pend_in = '0;
            count_in = '0;
            ovf_in = 1'b0;
            colon_in = 1'b0;
            term_in = 1'b0;
            user_in = '0;
            pass_in = '0;
         end else begin
            pad_in = pad_upd;
            acc_in = acc_upd;
            pend_in = pend_upd;
            count_in = count_upd;
            ovf_in = ovf_upd;
            colon_in = colon_upd;
            term_in = term_upd;
            user_in = user_upd;
            pass_in = pass_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= 1'b0;
         acc_ff <= '0;
         pend_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         colon_ff <= 1'b0;
         term_ff <= 1'b0;
         user_ff <= '0;
         pass_ff <= '0;
      end else begin
         pad_ff <= pad_in;
         acc_ff <= acc_in;
         pend_ff <= pend_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         colon_ff <= colon_in;
         term_ff <= term_in;
         user_ff <= user_in;
         pass_ff <= pass_in;
      end
   end

   // output register plus one parked status for a last char that also emits a byte
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         stat_pend_ff <= 1'b0;
      end else if (pop) begin
         if (emit) begin
            out_valid_ff <= 1'b1;
            stat_pend_ff <= tok.last;
         end else begin
            out_valid_ff <= tok.last;
         end
      end else if (stat_pend_ff && out_free) begin
         out_valid_ff <= 1'b1;
         stat_pend_ff <= 1'b0;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= emit ? byte_res : stat_res;
         stat_data_ff <= stat_res;
      end else if (stat_pend_ff && out_free) begin
         out_data_ff <= stat_data_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_byte = out_data_ff.out_byte;
   assign rsp_chan.field_select = out_data_ff.field_select;
   assign rsp_chan.is_status = out_data_ff.is_status;
   assign rsp_chan.status_code = out_data_ff.status_code;
   assign rsp_chan.end_of_run = out_data_ff.end_of_run;

   a_pend_needs_out: assert property (@(posedge clock) disable iff (reset)
      stat_pend_ff |-> out_valid_ff)
      else $error("parked status without a result in the output register");

   a_pend_bits_even: assert property (@(posedge clock) disable iff (reset)
      !pend_ff[0] && pend_ff != 3'd7)
      else $error("pending bit count is not 0, 2, 4 or 6");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop && tok.last |=> count_ff == '0 && !colon_ff && !ovf_ff && pend_ff == '0)
      else $error("run state not cleared after the last char");

   a_status_tagged: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff.is_status == out_data_ff.end_of_run)
      else $error("status result without end of run, or byte with it");

endmodule
